// ===== src/lfu_pkg.sv =====
// ----------------------------------------------------------------------------
// lfu_pkg: shared types and constants of the LFU cache table
// Field widths, command codes, sequencer states and table write controls.
// ----------------------------------------------------------------------------
package lfu_pkg;

    // Default table geometry.
    localparam int CAPACITY_DEF   = 16;
    localparam int COUNT_BITS_DEF = 16;

    // Payload widths.
    localparam int CAP_W   = 5;
    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;

    // Capacity register reset value.
    localparam logic [CAP_W-1:0] CAP_RST = 5'd16;

    // Command codes.
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // Value returned on a miss and on every put.
    localparam logic signed [VALUE_W-1:0] MISS_VALUE = -32'sd1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE,
        ST_DONE,
        ST_CFG_SCAN,
        ST_CFG_RANK
    } state_t;

    // Rank update rule applied by the update pass.
    typedef enum logic [1:0] {
        MODE_TOUCH,
        MODE_INSERT,
        MODE_DROP
    } mode_t;

    // Write strobes from the sequencer to the table.
    typedef struct packed {
        logic key_we;
        logic value_we;
        logic cnt_we;
        logic rank_we;
        logic valid_set;
        logic valid_clr;
    } tbl_wr_t;

endpackage

// ===== src/lfu_if.sv =====
// ----------------------------------------------------------------------------
// lfu_if: handshake channels of the LFU cache table
// Request, response and capacity configuration channels, valid/ready each.
// ----------------------------------------------------------------------------

// Request channel: one beat carries a get or a put.
interface lfu_req_if;
    logic                                valid;
    logic                                ready;
    logic                                command;
    logic signed [lfu_pkg::KEY_W-1:0]    key;
    logic signed [lfu_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output command, output key, output value, input ready);
    modport sink   (input valid, input command, input key, input value, output ready);
endinterface

// Response channel: one beat per request.
interface lfu_resp_if;
    logic                                valid;
    logic                                ready;
    logic                                hit;
    logic signed [lfu_pkg::VALUE_W-1:0]  read_value;
    logic                                evicted;

    modport source (output valid, output hit, output read_value, output evicted, input ready);
    modport sink   (input valid, input hit, input read_value, input evicted, output ready);
endinterface

// Configuration channel: one beat writes the capacity register.
interface lfu_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [lfu_pkg::CAP_W-1:0]           capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

// ===== src/lfu_cache_table.sv =====
// Sequence: a request runs a scan pass over the first n entries (n = effective
// capacity), a decision state, an optional rank pass on a hit or an insert,
// and a completion state that loads the response register once it is free.
// A new request is taken only back in idle, after the response is loaded;
// both passes share the table's one registered read port.
// Capacity write: drops the entries at or above the new capacity. Reset:
// asynchronous, empties the table at once, capacity returns to 16.
// ----------------------------------------------------------------------------
// lfu_cache_table: key-value cache with least-frequently-used replacement
// A small sequencer walks the table one entry per cycle to find the key, the
// first free slot and the victim (lowest count, then oldest access), then
// walks it again to age or renumber the recency ranks.
// ----------------------------------------------------------------------------
module lfu_cache_table #(
    parameter int CAPACITY   = lfu_pkg::CAPACITY_DEF,
    parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    lfu_cfg_if.sink     cfg,
    lfu_req_if.sink     req,
    lfu_resp_if.source  resp
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int NW    = (CNT_W > lfu_pkg::CAP_W) ? CNT_W : lfu_pkg::CAP_W;

    localparam logic [NW-1:0]         CAP_LIM   = NW'(CAPACITY);
    localparam logic [CNT_W-1:0]      PASS_FULL = CNT_W'(CAPACITY);
    localparam logic [COUNT_BITS-1:0] CNT_MAX   = '1;
    localparam logic [COUNT_BITS-1:0] CNT_ONE   = COUNT_BITS'(1);

    // Effective capacity: the register value limited to the table size.
    function automatic logic [CNT_W-1:0] eff_cap(input logic [lfu_pkg::CAP_W-1:0] c);
        logic [NW-1:0] ce;
        ce = NW'(c);
        return CNT_W'((ce < CAP_LIM) ? ce : CAP_LIM);
    endfunction

    // Control state.
    lfu_pkg::state_t                     state_reg, state_next;
    logic [lfu_pkg::CAP_W-1:0]           cap_reg, cap_next;
    logic [CNT_W-1:0]                    p_reg, p_next;
    logic [CNT_W-1:0]                    pass_end_reg, pass_end_next;
    logic                                d_vld_reg, d_vld_next;
    logic [CNT_W-1:0]                    j_reg, j_next;
    logic                                out_vld_reg, out_vld_next;

    // Request and scan results.
    logic [IDX_W-1:0]                    d_idx_reg, d_idx_next;
    logic                                cmd_reg, cmd_next;
    logic signed [lfu_pkg::KEY_W-1:0]    key_reg, key_next;
    logic signed [lfu_pkg::VALUE_W-1:0]  val_reg, val_next;
    logic                                hit_reg, hit_next;
    logic [IDX_W-1:0]                    found_reg, found_next;
    logic signed [lfu_pkg::VALUE_W-1:0]  found_val_reg, found_val_next;
    logic [COUNT_BITS-1:0]               found_cnt_reg, found_cnt_next;
    logic [IDX_W-1:0]                    found_rank_reg, found_rank_next;
    logic [CNT_W-1:0]                    nvalid_reg, nvalid_next;
    logic                                free_vld_reg, free_vld_next;
    logic [IDX_W-1:0]                    free_reg, free_next;
    logic                                vic_have_reg, vic_have_next;
    logic [IDX_W-1:0]                    vic_reg, vic_next;
    logic [COUNT_BITS-1:0]               vic_cnt_reg, vic_cnt_next;
    logic [IDX_W-1:0]                    vic_rank_reg, vic_rank_next;
    lfu_pkg::mode_t                      mode_reg, mode_next;
    logic [IDX_W-1:0]                    tgt_reg, tgt_next;
    logic [IDX_W-1:0]                    ref_rank_reg, ref_rank_next;
    logic                                ev_reg, ev_next;
    logic                                res_hit_reg, res_hit_next;
    logic signed [lfu_pkg::VALUE_W-1:0]  res_rd_reg, res_rd_next;
    logic                                out_hit_reg, out_hit_next;
    logic signed [lfu_pkg::VALUE_W-1:0]  out_rd_reg, out_rd_next;
    logic                                out_ev_reg, out_ev_next;

    // Table port.
    lfu_pkg::tbl_wr_t                    wr;
    logic [IDX_W-1:0]                    rd_addr;
    logic [IDX_W-1:0]                    ent_addr;
    logic [IDX_W-1:0]                    rank_addr;
    logic signed [lfu_pkg::KEY_W-1:0]    key_wdata;
    logic signed [lfu_pkg::VALUE_W-1:0]  value_wdata;
    logic [COUNT_BITS-1:0]               cnt_wdata;
    logic [IDX_W-1:0]                    rank_wdata;
    logic signed [lfu_pkg::KEY_W-1:0]    key_rd;
    logic signed [lfu_pkg::VALUE_W-1:0]  value_rd;
    logic [COUNT_BITS-1:0]               cnt_rd;
    logic [IDX_W-1:0]                    rank_rd;
    logic [CAPACITY-1:0]                 valid_vec;

    // Helpers.
    logic [CNT_W-1:0]                    n;
    logic                                entry_v;
    logic                                pass_done;
    logic                                full;
    logic [COUNT_BITS-1:0]               cnt_bump;
    logic [IDX_W-1:0]                    upd_rank;
    logic [IDX_W-1:0]                    ins_base;
    logic [IDX_W-1:0]                    slot;

    lfu_table #(
        .CAPACITY   (CAPACITY),
        .COUNT_BITS (COUNT_BITS),
        .IDX_W      (IDX_W)
    ) u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr          (wr),
        .rd_addr     (rd_addr),
        .ent_addr    (ent_addr),
        .rank_addr   (rank_addr),
        .key_wdata   (key_wdata),
        .value_wdata (value_wdata),
        .cnt_wdata   (cnt_wdata),
        .rank_wdata  (rank_wdata),
        .key_rd      (key_rd),
        .value_rd    (value_rd),
        .cnt_rd      (cnt_rd),
        .rank_rd     (rank_rd),
        .valid_vec   (valid_vec)
    );

    // Shared arithmetic: effective capacity, count bump and rank rules.
    assign n         = eff_cap(cap_reg);
    assign entry_v   = valid_vec[d_idx_reg];
    assign pass_done = (p_reg == pass_end_reg);
    assign full      = (nvalid_reg >= n);
    assign slot      = full ? vic_reg : free_reg;
    assign cnt_bump  = (found_cnt_reg == CNT_MAX) ? found_cnt_reg : found_cnt_reg + CNT_ONE;
    assign ins_base  = (ev_reg && (rank_rd > ref_rank_reg)) ? rank_rd - IDX_W'(1) : rank_rd;

    always_comb
    begin
        unique case (mode_reg)
            lfu_pkg::MODE_TOUCH:  upd_rank = (rank_rd < ref_rank_reg) ? rank_rd + IDX_W'(1)
                                                                     : rank_rd;
            lfu_pkg::MODE_INSERT: upd_rank = ins_base + IDX_W'(1);
            lfu_pkg::MODE_DROP:   upd_rank = (rank_rd > ref_rank_reg) ? rank_rd - IDX_W'(1)
                                                                     : rank_rd;
            default:              upd_rank = rank_rd;
        endcase
    end

    // Sequencer: next state, table controls and datapath updates.
    always_comb
    begin
        state_next      = state_reg;
        cap_next        = cap_reg;
        p_next          = p_reg;
        pass_end_next   = pass_end_reg;
        d_vld_next      = 1'b0;
        d_idx_next      = d_idx_reg;
        j_next          = j_reg;
        out_vld_next    = out_vld_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        hit_next        = hit_reg;
        found_next      = found_reg;
        found_val_next  = found_val_reg;
        found_cnt_next  = found_cnt_reg;
        found_rank_next = found_rank_reg;
        nvalid_next     = nvalid_reg;
        free_vld_next   = free_vld_reg;
        free_next       = free_reg;
        vic_have_next   = vic_have_reg;
        vic_next        = vic_reg;
        vic_cnt_next    = vic_cnt_reg;
        vic_rank_next   = vic_rank_reg;
        mode_next       = mode_reg;
        tgt_next        = tgt_reg;
        ref_rank_next   = ref_rank_reg;
        ev_next         = ev_reg;
        res_hit_next    = res_hit_reg;
        res_rd_next     = res_rd_reg;
        out_hit_next    = out_hit_reg;
        out_rd_next     = out_rd_reg;
        out_ev_next     = out_ev_reg;

        wr          = '0;
        rd_addr     = p_reg[IDX_W-1:0];
        ent_addr    = found_reg;
        rank_addr   = d_idx_reg;
        key_wdata   = key_reg;
        value_wdata = val_reg;
        cnt_wdata   = cnt_bump;
        rank_wdata  = '0;
        cfg.ready   = 1'b0;
        req.ready   = 1'b0;

        // The response register drains independently of the sequencer.
        if (out_vld_reg && resp.ready)
        begin
            out_vld_next = 1'b0;
        end

        unique case (state_reg)
            lfu_pkg::ST_IDLE:
            begin
                cfg.ready = 1'b1;
                req.ready = !cfg.valid;
                if (cfg.valid)
                begin
                    cap_next   = cfg.capacity;
                    j_next     = eff_cap(cfg.capacity);
                    state_next = lfu_pkg::ST_CFG_SCAN;
                end
                else if (req.valid)
                begin
                    cmd_next      = req.command;
                    key_next      = req.key;
                    val_next      = req.value;
                    hit_next      = 1'b0;
                    nvalid_next   = '0;
                    free_vld_next = 1'b0;
                    vic_have_next = 1'b0;
                    p_next        = '0;
                    pass_end_next = n;
                    state_next    = lfu_pkg::ST_SCAN;
                end
            end

            lfu_pkg::ST_SCAN:
            begin
                if (!pass_done)
                begin
                    d_vld_next = 1'b1;
                    d_idx_next = p_reg[IDX_W-1:0];
                    p_next     = p_reg + CNT_W'(1);
                end
                // One entry per cycle: key match, fill level, free slot, victim.
                if (d_vld_reg && entry_v)
                begin
                    nvalid_next = nvalid_reg + CNT_W'(1);
                    if (!hit_reg && (key_rd == key_reg))
                    begin
                        hit_next        = 1'b1;
                        found_next      = d_idx_reg;
                        found_val_next  = value_rd;
                        found_cnt_next  = cnt_rd;
                        found_rank_next = rank_rd;
                    end
                    if (!vic_have_reg || (cnt_rd < vic_cnt_reg) ||
                        ((cnt_rd == vic_cnt_reg) && (rank_rd > vic_rank_reg)))
                    begin
                        vic_have_next = 1'b1;
                        vic_next      = d_idx_reg;
                        vic_cnt_next  = cnt_rd;
                        vic_rank_next = rank_rd;
                    end
                end
                else if (d_vld_reg && !free_vld_reg)
                begin
                    free_vld_next = 1'b1;
                    free_next     = d_idx_reg;
                end
                if (pass_done)
                begin
                    state_next = lfu_pkg::ST_DECIDE;
                end
            end

            lfu_pkg::ST_DECIDE:
            begin
                res_hit_next  = hit_reg;
                res_rd_next   = lfu_pkg::MISS_VALUE;
                ev_next       = 1'b0;
                p_next        = '0;
                pass_end_next = n;
                state_next    = lfu_pkg::ST_DONE;
                if (hit_reg)
                begin
                    // Hit: bump the count, refresh recency, and on a put replace the value.
                    wr.cnt_we = 1'b1;
                    ent_addr  = found_reg;
                    cnt_wdata = cnt_bump;
                    if (cmd_reg == lfu_pkg::CMD_GET)
                    begin
                        res_rd_next = found_val_reg;
                    end
                    else
                    begin
                        wr.value_we = 1'b1;
                    end
                    mode_next     = lfu_pkg::MODE_TOUCH;
                    tgt_next      = found_reg;
                    ref_rank_next = found_rank_reg;
                    state_next    = lfu_pkg::ST_UPDATE;
                end
                else if ((cmd_reg == lfu_pkg::CMD_PUT) && (n != '0))
                begin
                    // Insert: into the victim's slot when full, else the lowest free one.
                    wr.key_we     = 1'b1;
                    wr.value_we   = 1'b1;
                    wr.cnt_we     = 1'b1;
                    wr.valid_set  = !full;
                    ent_addr      = slot;
                    cnt_wdata     = CNT_ONE;
                    mode_next     = lfu_pkg::MODE_INSERT;
                    tgt_next      = slot;
                    ref_rank_next = vic_rank_reg;
                    ev_next       = full;
                    state_next    = lfu_pkg::ST_UPDATE;
                end
            end

            lfu_pkg::ST_UPDATE:
            begin
                if (!pass_done)
                begin
                    d_vld_next = 1'b1;
                    d_idx_next = p_reg[IDX_W-1:0];
                    p_next     = p_reg + CNT_W'(1);
                end
                // Read-modify-write of one rank per cycle; outside a drop the target becomes newest.
                if (d_vld_reg)
                begin
                    rank_addr = d_idx_reg;
                    if (d_idx_reg == tgt_reg)
                    begin
                        wr.rank_we = (mode_reg != lfu_pkg::MODE_DROP);
                        rank_wdata = '0;
                    end
                    else if (entry_v)
                    begin
                        wr.rank_we = 1'b1;
                        rank_wdata = upd_rank;
                    end
                end
                if (pass_done)
                begin
                    state_next = (mode_reg == lfu_pkg::MODE_DROP) ? lfu_pkg::ST_CFG_SCAN
                                                                  : lfu_pkg::ST_DONE;
                end
            end

            lfu_pkg::ST_DONE:
            begin
                if (!out_vld_reg || resp.ready)
                begin
                    out_vld_next = 1'b1;
                    out_hit_next = res_hit_reg;
                    out_rd_next  = res_rd_reg;
                    out_ev_next  = ev_reg;
                    state_next   = lfu_pkg::ST_IDLE;
                end
            end

            lfu_pkg::ST_CFG_SCAN:
            begin
                // Look for the next valid entry at or above the new capacity.
                rd_addr = j_reg[IDX_W-1:0];
                if (j_reg == PASS_FULL)
                begin
                    state_next = lfu_pkg::ST_IDLE;
                end
                else if (valid_vec[j_reg[IDX_W-1:0]])
                begin
                    state_next = lfu_pkg::ST_CFG_RANK;
                end
                else
                begin
                    j_next = j_reg + CNT_W'(1);
                end
            end

            lfu_pkg::ST_CFG_RANK:
            begin
                // Drop the entry and close the gap in the ranks over the whole table.
                wr.valid_clr  = 1'b1;
                ent_addr      = j_reg[IDX_W-1:0];
                tgt_next      = j_reg[IDX_W-1:0];
                ref_rank_next = rank_rd;
                mode_next     = lfu_pkg::MODE_DROP;
                p_next        = '0;
                pass_end_next = PASS_FULL;
                j_next        = j_reg + CNT_W'(1);
                state_next    = lfu_pkg::ST_UPDATE;
            end

            default:
            begin
                state_next = lfu_pkg::ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lfu_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg      <= lfu_pkg::CAP_RST;
            p_reg        <= '0;
            pass_end_reg <= '0;
            d_vld_reg    <= 1'b0;
            j_reg        <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            cap_reg      <= cap_next;
            p_reg        <= p_next;
            pass_end_reg <= pass_end_next;
            d_vld_reg    <= d_vld_next;
            j_reg        <= j_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        d_idx_reg      <= d_idx_next;
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        hit_reg        <= hit_next;
        found_reg      <= found_next;
        found_val_reg  <= found_val_next;
        found_cnt_reg  <= found_cnt_next;
        found_rank_reg <= found_rank_next;
        nvalid_reg     <= nvalid_next;
        free_vld_reg   <= free_vld_next;
        free_reg       <= free_next;
        vic_have_reg   <= vic_have_next;
        vic_reg        <= vic_next;
        vic_cnt_reg    <= vic_cnt_next;
        vic_rank_reg   <= vic_rank_next;
        mode_reg       <= mode_next;
        tgt_reg        <= tgt_next;
        ref_rank_reg   <= ref_rank_next;
        ev_reg         <= ev_next;
        res_hit_reg    <= res_hit_next;
        res_rd_reg     <= res_rd_next;
        out_hit_reg    <= out_hit_next;
        out_rd_reg     <= out_rd_next;
        out_ev_reg     <= out_ev_next;
    end

    // Response beat.
    assign resp.valid      = out_vld_reg;
    assign resp.hit        = out_hit_reg;
    assign resp.read_value = out_rd_reg;
    assign resp.evicted    = out_ev_reg;

`ifndef SYNTHESIS
    // A new response beat appears only out of the completion state.
    a_resp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(state_reg == lfu_pkg::ST_DONE))
        else $error("response raised outside the completion state");

    // While idle, no entry is live at or above the effective capacity.
    a_no_entry_above_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lfu_pkg::ST_IDLE) |-> ((valid_vec >> n) == '0))
        else $error("valid entry above effective capacity");

    // A live entry always carries a nonzero use count.
    a_hit_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == lfu_pkg::ST_DECIDE) && hit_reg) |-> (found_cnt_reg != '0))
        else $error("hit entry with zero use count");

    // An insert into a table that is not full always finds a free slot.
    a_free_slot_found: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == lfu_pkg::ST_DECIDE) && (cmd_reg == lfu_pkg::CMD_PUT) &&
         !hit_reg && !full) |-> free_vld_reg)
        else $error("no free slot found for insert");
`endif

endmodule

// ===== src/lfu_table.sv =====
// ----------------------------------------------------------------------------
// lfu_table: entry storage of the LFU cache table
// Key, value, use count and recency rank memories with one registered read
// port, plus the per-entry valid flags, which reset clears.
// ----------------------------------------------------------------------------
module lfu_table #(
    parameter int CAPACITY   = lfu_pkg::CAPACITY_DEF,
    parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF,
    parameter int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lfu_pkg::tbl_wr_t                    wr,
    input  logic [IDX_W-1:0]                    rd_addr,
    input  logic [IDX_W-1:0]                    ent_addr,
    input  logic [IDX_W-1:0]                    rank_addr,
    input  logic signed [lfu_pkg::KEY_W-1:0]    key_wdata,
    input  logic signed [lfu_pkg::VALUE_W-1:0]  value_wdata,
    input  logic [COUNT_BITS-1:0]               cnt_wdata,
    input  logic [IDX_W-1:0]                    rank_wdata,
    output logic signed [lfu_pkg::KEY_W-1:0]    key_rd,
    output logic signed [lfu_pkg::VALUE_W-1:0]  value_rd,
    output logic [COUNT_BITS-1:0]               cnt_rd,
    output logic [IDX_W-1:0]                    rank_rd,
    output logic [CAPACITY-1:0]                 valid_vec
);

    logic signed [lfu_pkg::KEY_W-1:0]    key_mem   [CAPACITY];
    logic signed [lfu_pkg::VALUE_W-1:0]  value_mem [CAPACITY];
    logic [COUNT_BITS-1:0]               cnt_mem   [CAPACITY];
    logic [IDX_W-1:0]                    rank_mem  [CAPACITY];

    logic signed [lfu_pkg::KEY_W-1:0]    key_rd_reg;
    logic signed [lfu_pkg::VALUE_W-1:0]  value_rd_reg;
    logic [COUNT_BITS-1:0]               cnt_rd_reg;
    logic [IDX_W-1:0]                    rank_rd_reg;
    logic [CAPACITY-1:0]                 valid_reg;

    // Entry fields written by the sequencer at the entry address.
    always_ff @(posedge clk)
    begin
        if (wr.key_we)
        begin
            key_mem[ent_addr] <= key_wdata;
        end
        if (wr.value_we)
        begin
            value_mem[ent_addr] <= value_wdata;
        end
        if (wr.cnt_we)
        begin
            cnt_mem[ent_addr] <= cnt_wdata;
        end
        key_rd_reg   <= key_mem[rd_addr];
        value_rd_reg <= value_mem[rd_addr];
        cnt_rd_reg   <= cnt_mem[rd_addr];
    end

    // Ranks are rewritten one entry per cycle by the update pass.
    always_ff @(posedge clk)
    begin
        if (wr.rank_we)
        begin
            rank_mem[rank_addr] <= rank_wdata;
        end
        rank_rd_reg <= rank_mem[rd_addr];
    end

    // Valid flags live in flops so that reset empties the table at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (wr.valid_set)
            begin
                valid_reg[ent_addr] <= 1'b1;
            end
            if (wr.valid_clr)
            begin
                valid_reg[ent_addr] <= 1'b0;
            end
        end
    end

    assign key_rd    = key_rd_reg;
    assign value_rd  = value_rd_reg;
    assign cnt_rd    = cnt_rd_reg;
    assign rank_rd   = rank_rd_reg;
    assign valid_vec = valid_reg;

endmodule
